/* src/hdsb_pkg.sv */
// hdsb_pkg: ring sizes, event and status codes, beat types and ring pointer helpers
// for the half-duplex serial buffer engine; no dependencies
package hdsb_pkg;

	localparam int RX_DEPTH = 16;
	localparam int TX_DEPTH = 32;
	localparam int RX_PW = $clog2(RX_DEPTH);
	localparam int TX_PW = $clog2(TX_DEPTH);

	localparam int MODE_W = 3;
	localparam int DATA_W = 8;
	localparam int STATUS_W = 3;
	localparam int RX_COUNT_W = 4;
	localparam int TX_FREE_W = 5;
	localparam int HINT_W = 2;

	typedef logic [RX_PW-1:0] rx_ptr_t;
	typedef logic [TX_PW-1:0] tx_ptr_t;

	localparam logic [MODE_W-1:0] MODE_LINE_RX = 3'd0;
	localparam logic [MODE_W-1:0] MODE_HOST_READ = 3'd1;
	localparam logic [MODE_W-1:0] MODE_PUSH_BACK = 3'd2;
	localparam logic [MODE_W-1:0] MODE_HOST_WRITE = 3'd3;
	localparam logic [MODE_W-1:0] MODE_TX_EMPTY = 3'd4;
	localparam logic [MODE_W-1:0] MODE_TX_DONE = 3'd5;

	localparam logic [STATUS_W-1:0] ST_DONE = 3'd0;
	localparam logic [STATUS_W-1:0] ST_RX_FULL = 3'd1;
	localparam logic [STATUS_W-1:0] ST_RX_OFF = 3'd2;
	localparam logic [STATUS_W-1:0] ST_READ_EMPTY = 3'd3;
	localparam logic [STATUS_W-1:0] ST_TX_FULL = 3'd4;
	localparam logic [STATUS_W-1:0] ST_TX_IDLE = 3'd5;
	localparam logic [STATUS_W-1:0] ST_IGNORED = 3'd6;
	localparam logic [STATUS_W-1:0] ST_DISPLACED = 3'd7;

	localparam logic [HINT_W-1:0] HINT_NONE = 2'd0;
	localparam logic [HINT_W-1:0] HINT_IDLE = 2'd1;
	localparam logic [HINT_W-1:0] HINT_AWAKE = 2'd2;

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic [DATA_W-1:0] data_in;
		logic              last_of_transfer;
	} item_t;

	typedef struct packed {
		logic [STATUS_W-1:0]   status;
		logic [DATA_W-1:0]     data_out;
		logic [RX_COUNT_W-1:0] rx_count;
		logic [TX_FREE_W-1:0]  tx_free;
		logic                  receiver_enabled;
		logic [HINT_W-1:0]     idle_hint;
	} result_t;

	function automatic rx_ptr_t rx_inc(rx_ptr_t p);
		return (p == rx_ptr_t'(RX_DEPTH - 1)) ? '0 : p + rx_ptr_t'(1);
	endfunction

	function automatic rx_ptr_t rx_dec(rx_ptr_t p);
		return (p == '0) ? rx_ptr_t'(RX_DEPTH - 1) : p - rx_ptr_t'(1);
	endfunction

	function automatic rx_ptr_t rx_used(rx_ptr_t w, rx_ptr_t r);
		return w - r + ((w < r) ? rx_ptr_t'(RX_DEPTH) : rx_ptr_t'(0));
	endfunction

	function automatic tx_ptr_t tx_inc(tx_ptr_t p);
		return (p == tx_ptr_t'(TX_DEPTH - 1)) ? '0 : p + tx_ptr_t'(1);
	endfunction

	function automatic tx_ptr_t tx_used(tx_ptr_t w, tx_ptr_t r);
		return w - r + ((w < r) ? tx_ptr_t'(TX_DEPTH) : tx_ptr_t'(0));
	endfunction

	function automatic tx_ptr_t tx_room(tx_ptr_t w, tx_ptr_t r);
		return tx_ptr_t'(TX_DEPTH - 1) - tx_used(w, r);
	endfunction

endpackage

/* src/hdsb_in_if.sv */
// hdsb_in_if: valid/ready channel carrying one event beat into the engine
// depends on hdsb_pkg
interface hdsb_in_if;
	logic                         valid;
	logic                         ready;
	logic [hdsb_pkg::MODE_W-1:0]  mode;
	logic [hdsb_pkg::DATA_W-1:0]  data_in;
	logic                         last_of_transfer;

	modport source (output valid, output mode, output data_in, output last_of_transfer,
		input ready);
	modport sink (input valid, input mode, input data_in, input last_of_transfer,
		output ready);
endinterface

/* src/hdsb_out_if.sv */
// hdsb_out_if: valid/ready channel carrying one result beat out of the engine
// depends on hdsb_pkg
interface hdsb_out_if;
	logic                             valid;
	logic                             ready;
	logic [hdsb_pkg::STATUS_W-1:0]    status;
	logic [hdsb_pkg::DATA_W-1:0]      data_out;
	logic [hdsb_pkg::RX_COUNT_W-1:0]  rx_count;
	logic [hdsb_pkg::TX_FREE_W-1:0]   tx_free;
	logic                             receiver_enabled;
	logic [hdsb_pkg::HINT_W-1:0]      idle_hint;

	modport source (output valid, output status, output data_out, output rx_count,
		output tx_free, output receiver_enabled, output idle_hint, input ready);
	modport sink (input valid, input status, input data_out, input rx_count,
		input tx_free, input receiver_enabled, input idle_hint, output ready);
endinterface

/* src/half_duplex_serial_buffer_engine_core.sv */
// half_duplex_serial_buffer_engine_core: top level with input and result registers
// around hdsb_engine; depends on hdsb_pkg, hdsb_in_if, hdsb_out_if, hdsb_engine
//
// usage
//   req carries one event beat: mode, data_in, last_of_transfer
//   rsp carries exactly one result beat per event, in order
//   an event beat is taken into an input register; when the result register can
//   take it, the engine works the whole event and the result lands there
//   an accepted event passes the input register, then the result register,
//   before rsp.valid rises
//   throughput: one event per cycle while rsp is not stalled, set by the single pass through the
//   ring pointer and flag update between the two registers
//   while rsp is stalled the result register holds, one more event waits in
//   the input register, and req.ready drops until the result is taken
//   reset clears both rings to empty, switches the receiver on and disarms
//   transmission and completion; ring contents are not cleared
//   receive ring holds RX_DEPTH-1 bytes, transmit ring TX_DEPTH-1 bytes
module half_duplex_serial_buffer_engine_core (
	input  logic            clk,
	input  logic            arst_n,
	hdsb_in_if.sink         req,
	hdsb_out_if.source      rsp
);
	import hdsb_pkg::*;

	logic    valid_s1;
	item_t   item_s1;
	logic    valid_s2;
	result_t result_s2;
	result_t step_res;
	logic    advance;

	assign advance = valid_s1 && (!valid_s2 || rsp.ready);
	assign req.ready = !valid_s1 || advance;

	hdsb_engine u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (advance),
		.item   (item_s1),
		.res    (step_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (req.ready)
				valid_s1 <= req.valid;
			if (advance)
				valid_s2 <= 1'b1;
			else if (rsp.ready)
				valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready)
			item_s1 <= '{mode: req.mode, data_in: req.data_in,
				last_of_transfer: req.last_of_transfer};
		if (advance)
			result_s2 <= step_res;
	end

	assign rsp.valid = valid_s2;
	assign rsp.status = result_s2.status;
	assign rsp.data_out = result_s2.data_out;
	assign rsp.rx_count = result_s2.rx_count;
	assign rsp.tx_free = result_s2.tx_free;
	assign rsp.receiver_enabled = result_s2.receiver_enabled;
	assign rsp.idle_hint = result_s2.idle_hint;

	// a waiting event is neither lost nor altered while the result side stalls
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> (valid_s1 && $stable(item_s1)))
		else $error("pending event lost during stall");

endmodule

/* src/hdsb_engine.sv */
// hdsb_engine: receive and transmit rings, receiver and transmit flags, and the
// single-pass event step; depends on hdsb_pkg
module hdsb_engine (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             go,
	input  hdsb_pkg::item_t  item,
	output hdsb_pkg::result_t res
);
	import hdsb_pkg::*;

	logic [DATA_W-1:0] rx_mem [RX_DEPTH];
	logic [DATA_W-1:0] tx_mem [TX_DEPTH];

	rx_ptr_t rx_wp_q, rx_rp_q, rx_wp_n, rx_rp_n, rx_waddr, rx_wp_inc, rx_rp_inc;
	tx_ptr_t tx_wp_q, tx_rp_q, tx_wp_n, tx_rp_n, tx_wp_inc, tx_rp_inc;
	logic rx_on_q, tx_armed_q, comp_armed_q;
	logic rx_on_n, tx_armed_n, comp_armed_n;
	logic rx_we, tx_we;
	logic [STATUS_W-1:0] status;
	logic [DATA_W-1:0] dout;
	logic [HINT_W-1:0] hint;

	assign rx_wp_inc = rx_inc(rx_wp_q);
	assign rx_rp_inc = rx_inc(rx_rp_q);
	assign tx_wp_inc = tx_inc(tx_wp_q);
	assign tx_rp_inc = tx_inc(tx_rp_q);

	always_comb begin
		rx_wp_n = rx_wp_q;
		rx_rp_n = rx_rp_q;
		tx_wp_n = tx_wp_q;
		tx_rp_n = tx_rp_q;
		rx_on_n = rx_on_q;
		tx_armed_n = tx_armed_q;
		comp_armed_n = comp_armed_q;
		rx_we = 1'b0;
		rx_waddr = rx_wp_inc;
		tx_we = 1'b0;
		status = ST_DONE;
		dout = '0;
		hint = HINT_NONE;
		case (item.mode)
			MODE_LINE_RX: begin
				if (!rx_on_q) begin
					status = ST_RX_OFF;
				end else begin
					if (rx_wp_inc != rx_rp_q) begin
						rx_we = 1'b1;
						rx_wp_n = rx_wp_inc;
					end else begin
						status = ST_RX_FULL;
					end
					hint = HINT_AWAKE;
				end
			end
			MODE_HOST_READ: begin
				if (rx_wp_q == rx_rp_q) begin
					status = ST_READ_EMPTY;
					hint = HINT_IDLE;
				end else begin
					rx_rp_n = rx_rp_inc;
					dout = rx_mem[rx_rp_inc];
					if (item.last_of_transfer && rx_wp_q == rx_rp_inc)
						hint = HINT_IDLE;
				end
			end
			MODE_PUSH_BACK: begin
				if (rx_wp_inc == rx_rp_q) begin
					rx_wp_n = rx_dec(rx_wp_q);
					status = ST_DISPLACED;
				end
				rx_we = 1'b1;
				rx_waddr = rx_rp_q;
				rx_rp_n = rx_dec(rx_rp_q);
				hint = HINT_AWAKE;
			end
			MODE_HOST_WRITE: begin
				if (tx_wp_inc == tx_rp_q) begin
					status = ST_TX_FULL;
				end else begin
					tx_we = 1'b1;
					tx_wp_n = tx_wp_inc;
				end
				if (item.last_of_transfer)
					tx_armed_n = 1'b1;
			end
			MODE_TX_EMPTY: begin
				if (!tx_armed_q) begin
					status = ST_IGNORED;
				end else if (tx_wp_q != tx_rp_q) begin
					rx_on_n = 1'b0;
					tx_rp_n = tx_rp_inc;
					dout = tx_mem[tx_rp_inc];
				end else begin
					comp_armed_n = 1'b1;
					tx_armed_n = 1'b0;
					status = ST_TX_IDLE;
				end
			end
			MODE_TX_DONE: begin
				if (comp_armed_q) begin
					rx_on_n = 1'b1;
					comp_armed_n = 1'b0;
				end else begin
					status = ST_IGNORED;
				end
			end
			default: begin
				status = ST_IGNORED;
			end
		endcase
	end

	always_comb begin
		res.status = status;
		res.data_out = dout;
		res.rx_count = RX_COUNT_W'(rx_used(rx_wp_n, rx_rp_n));
		res.tx_free = TX_FREE_W'(tx_room(tx_wp_n, tx_rp_n));
		res.receiver_enabled = rx_on_n;
		res.idle_hint = hint;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_wp_q <= '0;
			rx_rp_q <= '0;
			tx_wp_q <= '0;
			tx_rp_q <= '0;
			rx_on_q <= 1'b1;
			tx_armed_q <= 1'b0;
			comp_armed_q <= 1'b0;
		end else if (go) begin
			rx_wp_q <= rx_wp_n;
			rx_rp_q <= rx_rp_n;
			tx_wp_q <= tx_wp_n;
			tx_rp_q <= tx_rp_n;
			rx_on_q <= rx_on_n;
			tx_armed_q <= tx_armed_n;
			comp_armed_q <= comp_armed_n;
		end
	end

	always_ff @(posedge clk) begin
		if (go && rx_we)
			rx_mem[rx_waddr] <= item.data_in;
		if (go && tx_we)
			tx_mem[tx_wp_inc] <= item.data_in;
	end

	// receiver stays off only while a transmission or its completion is pending
	a_rx_off_pending: assert property (@(posedge clk) disable iff (!arst_n)
		!rx_on_q |-> (tx_armed_q || comp_armed_q))
		else $error("receiver off with nothing pending");

	a_rx_off_no_store: assert property (@(posedge clk) disable iff (!arst_n)
		(go && item.mode == MODE_LINE_RX && !rx_on_q) |=> ($stable(rx_wp_q) && $stable(rx_rp_q)))
		else $error("line byte stored while receiver off");

	a_ptr_range: assert property (@(posedge clk) disable iff (!arst_n)
		({1'b0, rx_wp_q} < (RX_PW+1)'(RX_DEPTH)) && ({1'b0, rx_rp_q} < (RX_PW+1)'(RX_DEPTH))
		&& ({1'b0, tx_wp_q} < (TX_PW+1)'(TX_DEPTH)) && ({1'b0, tx_rp_q} < (TX_PW+1)'(TX_DEPTH)))
		else $error("ring pointer out of range");

endmodule
